// ===== sv/amc_pkg.sv =====
`default_nettype none
package amc_pkg;

  // value format
  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;

  // stream payload widths
  localparam int NUM_IN     = 12;
  localparam int IN_DATA_W  = ((NUM_IN * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_USER_W = 3;

  // Q2.30 trig / rotation format
  localparam int Q30   = 30;
  localparam int U_W   = 32;
  localparam int ROT_W = 33;
  localparam int PH_W  = 32;
  localparam int F_W   = PH_W - 3;
  localparam logic [U_W-1:0] Q30_ONE  = U_W'(1) << Q30;
  localparam logic [U_W-1:0] Q30_HALF = U_W'(1) << (Q30 - 1);

  // 2*pi in value format, and reciprocals for the two constant divisions
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] TP_L = (TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam int TP_W = $clog2(TP_L + 64'd1);
  localparam logic [63:0] RECIP_L = ((64'd1 << VALUE_WIDTH) + TP_L - 64'd1) / TP_L;
  localparam int RC_W = $clog2(RECIP_L + 64'd1);
  localparam logic [63:0] RP_L = (64'd1 << (PH_W + TP_W)) / TP_L;
  localparam int RP_W = $clog2(RP_L + 64'd1);
  localparam int R0_W = TP_W + 2;

  localparam logic [31:0] QUARTER_PI_Q32 = 32'hC90FDAA2;
  localparam int PI4_SHIFT = 31;

  // Taylor coefficients, Q2.30
  localparam logic [U_W-1:0] SIN_K = U_W'(2959);
  localparam logic [U_W-1:0] COS_K = U_W'(296);
  localparam logic [U_W-1:0] SIN_C [4] = '{U_W'(213044), U_W'(8947849),
                                          U_W'(178956971), U_W'(1073741824)};
  localparam logic [U_W-1:0] COS_C [4] = '{U_W'(26631), U_W'(1491308),
                                          U_W'(44739243), U_W'(536870912)};

  // quadrant codes (top two phase bits)
  localparam logic [1:0] QD_0 = 2'd0;
  localparam logic [1:0] QD_1 = 2'd1;
  localparam logic [1:0] QD_2 = 2'd2;
  localparam logic [1:0] QD_3 = 2'd3;

  // column codes
  localparam logic [1:0] COL_X   = 2'd0;
  localparam logic [1:0] COL_Y   = 2'd1;
  localparam logic [1:0] COL_Z   = 2'd2;
  localparam logic [1:0] COL_POS = 2'd3;

  // pipeline depths
  localparam int SC_LAT   = 16;
  localparam int ROT_LAT  = 2;
  localparam int COL_LAT  = 5;
  localparam int PIPE_LAT = SC_LAT + ROT_LAT + COL_LAT;

  localparam int TERM_W = VALUE_WIDTH + ROT_W - Q30 + 1;
  localparam int SUM_W  = TERM_W + 2;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic signed [ROT_W-1:0] rot_t;

  typedef struct packed {
    val_t shear_yz;
    val_t shear_xz;
    val_t shear_xy;
    val_t scale_z;
    val_t scale_y;
    val_t scale_x;
    val_t pos_z;
    val_t pos_y;
    val_t pos_x;
  } side_t;

  // unsigned Q2.30 product, round half up
  function automatic logic [U_W-1:0] umul30(input logic [U_W-1:0] a,
                                            input logic [U_W-1:0] b);
    logic [2*U_W-1:0] p;
    p = (2*U_W)'(a) * (2*U_W)'(b) + (2*U_W)'(Q30_HALF);
    return p[Q30 +: U_W];
  endfunction

  // signed Q2.30 product, round half away from zero
  function automatic rot_t smul30(input rot_t a, input rot_t b);
    logic [ROT_W-1:0]   ma;
    logic [ROT_W-1:0]   mb;
    logic [2*ROT_W-1:0] p;
    logic [ROT_W-1:0]   m;
    ma = a[ROT_W-1] ? ROT_W'(-a) : ROT_W'(a);
    mb = b[ROT_W-1] ? ROT_W'(-b) : ROT_W'(b);
    p  = (2*ROT_W)'(ma) * (2*ROT_W)'(mb) + (2*ROT_W)'(Q30_HALF);
    m  = p[Q30 +: ROT_W];
    return (a[ROT_W-1] ^ b[ROT_W-1]) ? rot_t'(-m) : rot_t'(m);
  endfunction

endpackage
`default_nettype wire

// ===== sv/affine_matrix_compose_top.sv =====
// Channel  Dir  Ports                     Payload (low bit up)
// in       in   in_tvalid/tready/tdata    pos_x pos_y pos_z angle_x angle_y angle_z
//                                         scale_x scale_y scale_z shear_xy shear_xz
//                                         shear_yz, 32 bits each
// out      out  out_tvalid/tready/tdata   tdata: row0 row1 row2; tuser: column_index,
//               /tuser/tlast              overflow; tlast: last_column
//
// One transform produces four transfers (columns 0..2, then position) on the
// single result channel, which limits the sustained rate.
// The path from input transfer to first column is the 23 pipeline stages plus
// the column emitter.
// Reset is synchronous, active low, and clears only valid/control state.
// out_tready low freezes the emitter; the pipeline stalls (in_tready low) whenever
// a finished transform sits in the last stage, until the emitter has taken it.
`default_nettype none
module affine_matrix_compose_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
  // shear_xy, shear_xz, shear_yz
  input  wire logic [amc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // row0_value, row1_value, row2_value
  output logic [amc_pkg::OUT_DATA_W-1:0]       out_tdata,
  // column_index[1:0], overflow[2]
  output logic [amc_pkg::OUT_USER_W-1:0]       out_tuser,
  output logic                                 out_tlast
);
  import amc_pkg::*;

  localparam int VW      = VALUE_WIDTH;
  localparam int ST_TAP  = SC_LAT + ROT_LAT - 1;

  // pipeline control: whole pipe moves together, held by the last stage
  logic                adv;
  logic                accept;
  logic                take;
  logic                emit_free;
  logic [PIPE_LAT-1:0] v_r;
  side_t               side_r [PIPE_LAT];
  side_t               in_side;
  val_t                ang [3];

  // lane outputs
  rot_t                s_w [3];
  rot_t                c_w [3];
  rot_t                rot_w [3][3];
  val_t                st_w [3][3];
  val_t                lin_w [3][3];
  logic [2:0]          ovf_w [3];

  // column emitter
  logic                emit_v_r;
  logic [1:0]          col_r;
  val_t                lin_r [3][3];
  val_t                pos_r [3];
  logic                ovf_r;
  val_t                row_sel [3];

  // unpack the input transfer
  always_comb begin
    in_side.pos_x    = in_tdata[0*VW +: VW];
    in_side.pos_y    = in_tdata[1*VW +: VW];
    in_side.pos_z    = in_tdata[2*VW +: VW];
    ang[0]           = in_tdata[3*VW +: VW];
    ang[1]           = in_tdata[4*VW +: VW];
    ang[2]           = in_tdata[5*VW +: VW];
    in_side.scale_x  = in_tdata[6*VW +: VW];
    in_side.scale_y  = in_tdata[7*VW +: VW];
    in_side.scale_z  = in_tdata[8*VW +: VW];
    in_side.shear_xy = in_tdata[9*VW +: VW];
    in_side.shear_xz = in_tdata[10*VW +: VW];
    in_side.shear_yz = in_tdata[11*VW +: VW];
  end

  assign adv       = !v_r[PIPE_LAT-1];
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;
  assign emit_free = !emit_v_r || (out_tready && col_r == COL_POS);
  assign take      = v_r[PIPE_LAT-1] && emit_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[PIPE_LAT-2:0], accept};
    end else if (take) begin
      v_r[PIPE_LAT-1] <= 1'b0;
    end
  end

  // side values ride along with the angle pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      for (int k = 1; k < PIPE_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // one sine/cosine lane per Euler angle
  for (genvar g = 0; g < 3; g++) begin : g_sc
    amc_sincos u_sc (
      .clk   (clk),
      .en    (adv),
      .angle (ang[g]),
      .sin_q (s_w[g]),
      .cos_q (c_w[g])
    );
  end

  amc_rot u_rot (
    .clk   (clk),
    .en    (adv),
    .sx    (s_w[0]),
    .cx    (c_w[0]),
    .sy    (s_w[1]),
    .cy    (c_w[1]),
    .sz    (s_w[2]),
    .cz    (c_w[2]),
    .rot_q (rot_w)
  );

  // columns of the upper-triangular stretch matrix
  always_comb begin
    st_w[0][0] = side_r[ST_TAP].scale_x;
    st_w[0][1] = '0;
    st_w[0][2] = '0;
    st_w[1][0] = side_r[ST_TAP].shear_xy;
    st_w[1][1] = side_r[ST_TAP].scale_y;
    st_w[1][2] = '0;
    st_w[2][0] = side_r[ST_TAP].shear_xz;
    st_w[2][1] = side_r[ST_TAP].shear_yz;
    st_w[2][2] = side_r[ST_TAP].scale_z;
  end

  // one lane per output column
  for (genvar j = 0; j < 3; j++) begin : g_col
    amc_col u_col (
      .clk   (clk),
      .en    (adv),
      .st    (st_w[j]),
      .rot   (rot_w),
      .lin_q (lin_w[j]),
      .ovf_q (ovf_w[j])
    );
  end

  // merge: capture the finished transform, fold the overflow flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_v_r <= 1'b0;
      col_r    <= COL_X;
    end else if (take) begin
      emit_v_r <= 1'b1;
      col_r    <= COL_X;
    end else if (emit_v_r && out_tready) begin
      if (col_r == COL_POS) begin
        emit_v_r <= 1'b0;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lin_r    <= lin_w;
      pos_r[0] <= side_r[PIPE_LAT-1].pos_x;
      pos_r[1] <= side_r[PIPE_LAT-1].pos_y;
      pos_r[2] <= side_r[PIPE_LAT-1].pos_z;
      ovf_r    <= |{ovf_w[0], ovf_w[1], ovf_w[2]};
    end
  end

  always_comb begin
    case (col_r)
      COL_X:   row_sel = lin_r[0];
      COL_Y:   row_sel = lin_r[1];
      COL_Z:   row_sel = lin_r[2];
      COL_POS: row_sel = pos_r;
      default: row_sel = pos_r;
    endcase
  end

  assign out_tvalid = emit_v_r;
  assign out_tdata  = OUT_DATA_W'({row_sel[2], row_sel[1], row_sel[0]});
  assign out_tuser  = {ovf_r, col_r};
  assign out_tlast  = (col_r == COL_POS);

`ifndef ASSERT_OFF
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out_tvalid && col_r == COL_X))
    else $error("emitter did not start at column 0 after capture");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && col_r == $past(col_r) + 2'd1))
    else $error("column index did not advance by one");

  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> $stable(out_tuser[2]))
    else $error("overflow flag changed within one transform");

  a_next_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid || col_r == COL_X))
    else $error("new transform did not begin at column 0");
`endif

endmodule
`default_nettype wire

// ===== sv/amc_sincos.sv =====
`default_nettype none
module amc_sincos (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire amc_pkg::val_t angle,
  output amc_pkg::rot_t      sin_q,
  output amc_pkg::rot_t      cos_q
);
  import amc_pkg::*;

  localparam int M1_W = VALUE_WIDTH + RC_W + 1;
  localparam int M2_W = RC_W + TP_W + 2;
  localparam int PM_W = TP_W + RP_W;
  localparam int M6_W = PH_W + TP_W;
  localparam int P9_W = F_W + 1 + 32;
  localparam logic signed [R0_W-1:0] TP_S = R0_W'(TP_L);

  // reduction and phase
  logic signed [M1_W-1:0] m1_r;
  val_t                   a1_r;
  logic signed [M2_W-1:0] m2_r;
  val_t                   a2_r;
  logic signed [R0_W-1:0] r0_r;
  logic [TP_W-1:0]        r4_r, r5_r, r6_r;
  logic [PM_W-1:0]        pm_r;
  logic [PH_W-1:0]        pe_r, ph_r;
  logic [M6_W-1:0]        m6_r;
  // polynomial
  logic [F_W:0]           fa_r;
  logic [2:0]             oct_r [8];
  logic [U_W-1:0]         x_r [6];
  logic [U_W-1:0]         x2_r [5];
  logic [U_W-1:0]         ts_r [4];
  logic [U_W-1:0]         tc_r [4];
  logic [U_W-1:0]         sv_r, cv_r;

  logic signed [M1_W-1:0] m1_nxt;
  logic signed [M2_W-1:0] m2_nxt;
  logic signed [M2_W-1:0] a2_ext;
  logic signed [R0_W-1:0] r0_nxt;
  logic [TP_W-1:0]        r4_nxt;
  logic [PH_W-1:0]        pe_nxt;
  logic [M6_W-1:0]        rem;
  logic [P9_W-1:0]        xp;
  rot_t                   ps, pc, s_nxt, c_nxt;

  always_comb begin
    m1_nxt = M1_W'(angle) * M1_W'($signed({1'b0, RC_W'(RECIP_L)}));
    m2_nxt = M2_W'($signed(m1_r[M1_W-1 -: RC_W+1])) *
             M2_W'($signed({1'b0, TP_W'(TP_L)}));
    a2_ext = M2_W'(a2_r);
    r0_nxt = R0_W'(a2_ext - m2_r);
    if (r0_r < 0) begin
      r4_nxt = TP_W'(r0_r + TP_S);
    end else if (r0_r >= TP_S) begin
      r4_nxt = TP_W'(r0_r - TP_S);
    end else begin
      r4_nxt = TP_W'(r0_r);
    end
    pe_nxt = PH_W'(pm_r >> TP_W);
    rem    = {r6_r, PH_W'(0)} - m6_r;
    xp     = P9_W'(fa_r) * P9_W'(QUARTER_PI_Q32);
    ps     = oct_r[7][0] ? rot_t'(cv_r) : rot_t'(sv_r);
    pc     = oct_r[7][0] ? rot_t'(sv_r) : rot_t'(cv_r);
    case (oct_r[7][2:1])
      QD_0: begin
        s_nxt = ps;
        c_nxt = pc;
      end
      QD_1: begin
        s_nxt = pc;
        c_nxt = -ps;
      end
      QD_2: begin
        s_nxt = -ps;
        c_nxt = -pc;
      end
      default: begin
        s_nxt = -pc;
        c_nxt = ps;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= m1_nxt;
      a1_r <= angle;
      m2_r <= m2_nxt;
      a2_r <= a1_r;
      r0_r <= r0_nxt;
      r4_r <= r4_nxt;
      pm_r <= PM_W'(r4_r) * PM_W'(RP_W'(RP_L));
      r5_r <= r4_r;
      pe_r <= pe_nxt;
      m6_r <= M6_W'(pe_nxt) * M6_W'(TP_W'(TP_L));
      r6_r <= r5_r;
      ph_r <= (rem >= M6_W'(TP_L)) ? pe_r + PH_W'(1) : pe_r;
      // octant fold
      oct_r[0] <= ph_r[PH_W-1 -: 3];
      fa_r     <= ph_r[F_W] ? (F_W+1)'(Q30_HALF) - (F_W+1)'(ph_r[F_W-1:0])
                            : (F_W+1)'(ph_r[F_W-1:0]);
      for (int k = 1; k < 8; k++) begin
        oct_r[k] <= oct_r[k-1];
      end
      x_r[0] <= U_W'(xp >> PI4_SHIFT);
      for (int k = 1; k < 6; k++) begin
        x_r[k] <= x_r[k-1];
      end
      x2_r[0] <= umul30(x_r[0], x_r[0]);
      for (int k = 1; k < 5; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
      // Horner steps
      ts_r[0] <= SIN_C[0] - umul30(x2_r[0], SIN_K);
      tc_r[0] <= COS_C[0] - umul30(x2_r[0], COS_K);
      for (int k = 1; k < 4; k++) begin
        ts_r[k] <= SIN_C[k] - umul30(x2_r[k], ts_r[k-1]);
        tc_r[k] <= COS_C[k] - umul30(x2_r[k], tc_r[k-1]);
      end
      sv_r  <= umul30(x_r[5], ts_r[3]);
      cv_r  <= Q30_ONE - umul30(x2_r[4], tc_r[3]);
      sin_q <= s_nxt;
      cos_q <= c_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/amc_rot.sv =====
`default_nettype none
module amc_rot (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire amc_pkg::rot_t sx,
  input  wire amc_pkg::rot_t cx,
  input  wire amc_pkg::rot_t sy,
  input  wire amc_pkg::rot_t cy,
  input  wire amc_pkg::rot_t sz,
  input  wire amc_pkg::rot_t cz,
  output amc_pkg::rot_t      rot_q [3][3]   // [column][row]
);
  import amc_pkg::*;

  rot_t cycz_r, cysz_r, czsx_r, cxsz_r, cxcz_r, sxsy_r, cysx_r, sxsz_r, cxsy_r, cxcy_r;
  rot_t sy_r, sz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // pair products
      cycz_r <= smul30(cy, cz);
      cysz_r <= smul30(cy, sz);
      czsx_r <= smul30(cz, sx);
      cxsz_r <= smul30(cx, sz);
      cxcz_r <= smul30(cx, cz);
      sxsy_r <= smul30(sx, sy);
      cysx_r <= smul30(cy, sx);
      sxsz_r <= smul30(sx, sz);
      cxsy_r <= smul30(cx, sy);
      cxcy_r <= smul30(cx, cy);
      sy_r   <= sy;
      sz_r   <= sz;
      // triple products and sums
      rot_q[0][0] <= cycz_r;
      rot_q[0][1] <= cysz_r;
      rot_q[0][2] <= -sy_r;
      rot_q[1][0] <= smul30(czsx_r, sy_r) - cxsz_r;
      rot_q[1][1] <= cxcz_r + smul30(sxsy_r, sz_r);
      rot_q[1][2] <= cysx_r;
      rot_q[2][0] <= sxsz_r + smul30(cxcz_r, sy_r);
      rot_q[2][1] <= smul30(cxsy_r, sz_r) - czsx_r;
      rot_q[2][2] <= cxcy_r;
    end
  end

endmodule
`default_nettype wire

// ===== sv/amc_col.sv =====
`default_nettype none
module amc_col (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire amc_pkg::val_t st [3],        // column of the stretch matrix
  input  wire amc_pkg::rot_t rot [3][3],    // [column][row]
  output amc_pkg::val_t      lin_q [3],
  output logic [2:0]         ovf_q
);
  import amc_pkg::*;

  localparam int PR_W = VALUE_WIDTH + ROT_W;
  localparam logic signed [SUM_W-1:0] MAXV = SUM_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);

  logic [VALUE_WIDTH-1:0]   ma_nxt [3];
  logic [ROT_W-1:0]         mr_nxt [3][3];
  logic                     ng_nxt [3][3];
  logic [PR_W:0]            rnd [3][3];
  logic signed [TERM_W-1:0] term_nxt [3][3];
  logic signed [SUM_W-1:0]  sum_nxt [3];

  logic [VALUE_WIDTH-1:0]   ma_r [3];
  logic [ROT_W-1:0]         mr_r [3][3];
  logic                     ng_r [3][3];
  logic                     ng2_r [3][3];
  logic [PR_W-1:0]          prod_r [3][3];
  logic signed [TERM_W-1:0] term_r [3][3];
  logic signed [SUM_W-1:0]  sum_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ma_nxt[k] = st[k][VALUE_WIDTH-1] ? VALUE_WIDTH'(-st[k]) : VALUE_WIDTH'(st[k]);
      for (int i = 0; i < 3; i++) begin
        mr_nxt[k][i] = rot[k][i][ROT_W-1] ? ROT_W'(-rot[k][i]) : ROT_W'(rot[k][i]);
        ng_nxt[k][i] = st[k][VALUE_WIDTH-1] ^ rot[k][i][ROT_W-1];
        rnd[k][i] = (PR_W+1)'(prod_r[k][i]) + (PR_W+1)'(Q30_HALF);
        term_nxt[k][i] = ng2_r[k][i] ? -$signed(TERM_W'(rnd[k][i] >> Q30))
                                     : $signed(TERM_W'(rnd[k][i] >> Q30));
      end
    end
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = SUM_W'(term_r[0][i]) + SUM_W'(term_r[1][i]) + SUM_W'(term_r[2][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ma_r[k] <= ma_nxt[k];
        for (int i = 0; i < 3; i++) begin
          mr_r[k][i]   <= mr_nxt[k][i];
          ng_r[k][i]   <= ng_nxt[k][i];
          prod_r[k][i] <= PR_W'(ma_r[k]) * PR_W'(mr_r[k][i]);
          ng2_r[k][i]  <= ng_r[k][i];
          term_r[k][i] <= term_nxt[k][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= sum_nxt[i];
        // clamp to the value range
        if (sum_r[i] > MAXV) begin
          lin_q[i] <= VALUE_WIDTH'(MAXV);
          ovf_q[i] <= 1'b1;
        end else if (sum_r[i] < MINV) begin
          lin_q[i] <= VALUE_WIDTH'(MINV);
          ovf_q[i] <= 1'b1;
        end else begin
          lin_q[i] <= VALUE_WIDTH'(sum_r[i]);
          ovf_q[i] <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire
